FILE: hdl/bblp_pkg.sv
// ----------------------------------------------------------------------------
// Box blur line pass package
// Shared widths, register indexes and the control/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bblp_pkg;

    localparam int MAX_RADIUS  = 16;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int NUM_CH      = 4;
    localparam int CH_W        = 8;
    localparam int PIX_W       = NUM_CH * CH_W;
    localparam int SUM_W       = $clog2(STORE_DEPTH * ((1 << CH_W) - 1) + 1);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int RAD_W       = 5;
    localparam int LEN_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd1;

    localparam logic [RAD_W-1:0] RADIUS_RESET      = 5'd1;
    localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 16'd640;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  chan_vec_t;

    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic drop;
        logic div_start;
        logic load_out;
        logic advance;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_go;
        logic need_drop;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/bblp_div.sv
// ----------------------------------------------------------------------------
// Box blur channel divider
// Four restoring divider lanes sharing one divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bblp_div
    import bblp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire sum_vec_t         dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output chan_vec_t             quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    sum_vec_t                     q_reg;
    sum_vec_t                     q_next;
    logic [NUM_CH-1:0][CNT_W-1:0] rem_reg;
    logic [NUM_CH-1:0][CNT_W-1:0] rem_next;
    logic [CNT_W-1:0]             div_reg;
    logic                         zero_reg;
    logic [CNT_W:0]               rem_sh;
    logic                         fits;

    always_comb
    begin
        rem_sh = '0;
        fits   = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem_sh      = {rem_reg[c], q_reg[c][SUM_W-1]};
            fits        = (rem_sh >= {1'b0, div_reg});
            rem_next[c] = fits ? CNT_W'(rem_sh - {1'b0, div_reg}) : CNT_W'(rem_sh);
            q_next[c]   = {q_reg[c][SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            quotient[c] = zero_reg ? '0 : q_reg[c][CH_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hdl/bblp_ctrl.sv
// ----------------------------------------------------------------------------
// Box blur controller
// Sequences accept, window drop, divide, output and line bookkeeping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bblp_ctrl
    import bblp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DROP  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.emit_go)
                begin
                    if (status.need_drop)
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = S_DROP;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output loaded while the output register is full");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV))
        else $error("divider started without waiting for it");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("new request taken before the previous one was processed");

    a_read_then_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |=> cmd.drop)
        else $error("window read not followed by a drop");
`endif

endmodule

`default_nettype wire

FILE: hdl/bblp_dp.sv
// ----------------------------------------------------------------------------
// Box blur datapath
// Configuration, running sums, window store, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bblp_dp
    import bblp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [PIX_W-1:0]     in_data,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [PIX_W-1:0]          out_data,
    output logic                      out_last
);

    logic [RAD_W-1:0]   radius_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [RAD_W-1:0]   r_eff;
    logic [LEN_W-1:0]   len_eff;

    logic [PIX_W-1:0]   store [STORE_DEPTH];
    logic [PIX_W-1:0]   rd_data_reg;

    sum_vec_t           sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [LEN_W-1:0]   x_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               last_reg;
    logic               ge_reg;

    logic               last_in;
    logic               ge_in;
    logic [LEN_W-1:0]   x_init;
    logic [IDX_W:0]     span;
    logic [IDX_W:0]     rd_diff;
    logic [IDX_W-1:0]   rd_init;

    logic               div_done;
    chan_vec_t          quot;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_last_reg;

    assign r_eff   = ((RAD_W + 1)'(radius_reg) > (RAD_W + 1)'(MAX_RADIUS)) ?
                     RAD_W'(MAX_RADIUS) : radius_reg;
    assign len_eff = (len_reg == '0) ? LEN_W'(1) : len_reg;

    assign last_in = ((LEN_W + 1)'(pos_reg) + 1'b1) >= (LEN_W + 1)'(len_eff);
    assign ge_in   = pos_reg >= LEN_W'(r_eff);
    assign x_init  = ge_in ? (pos_reg - LEN_W'(r_eff)) : '0;
    assign span    = (IDX_W + 1)'({r_eff, 1'b1});
    assign rd_diff = {1'b0, wr_idx_reg} - span;
    assign rd_init = rd_diff[IDX_W] ? (rd_diff[IDX_W-1:0] + IDX_W'(STORE_DEPTH)) :
                     rd_diff[IDX_W-1:0];

    always_comb
    begin
        status.emit_go   = last_reg ?
                           ((x_reg < len_eff) && (n_reg < CNT_W'(STORE_DEPTH))) :
                           ((n_reg == '0) && ge_reg);
        status.need_drop = (LEN_W + 1)'(x_reg) >= ((LEN_W + 1)'(r_eff) + 1'b1);
        status.div_done  = div_done;
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            len_reg    <= LINE_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:      radius_reg <= cfg_data[RAD_W-1:0];
                REG_LINE_LENGTH: len_reg    <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            store[wr_idx_reg] <= pix_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= store[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            x_reg      <= '0;
            n_reg      <= '0;
            last_reg   <= 1'b0;
            ge_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sum_reg[c] <= sum_reg[c] + SUM_W'(in_data[c*CH_W +: CH_W]);
                end
                cnt_reg    <= cnt_reg + 1'b1;
                x_reg      <= x_init;
                n_reg      <= '0;
                last_reg   <= last_in;
                ge_reg     <= ge_in;
                rd_idx_reg <= rd_init;
            end
            else if (cmd.drop)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sum_reg[c] <= sum_reg[c] - SUM_W'(rd_data_reg[c*CH_W +: CH_W]);
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (cmd.advance)
            begin
                x_reg      <= x_reg + 1'b1;
                n_reg      <= n_reg + 1'b1;
                rd_idx_reg <= (rd_idx_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 :
                              (rd_idx_reg + 1'b1);
            end
            else if (cmd.finish)
            begin
                if (last_reg)
                begin
                    sum_reg    <= '0;
                    cnt_reg    <= '0;
                    pos_reg    <= '0;
                    wr_idx_reg <= '0;
                end
                else
                begin
                    pos_reg    <= pos_reg + 1'b1;
                    wr_idx_reg <= (wr_idx_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 :
                                  (wr_idx_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= in_data;
        end
    end

    bblp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= quot;
            out_last_reg <= ((LEN_W + 1)'(x_reg) + 1'b1) == (LEN_W + 1)'(len_eff);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/box_blur_line_pass_core.sv
// ----------------------------------------------------------------------------
// Box blur line pass core
// One-dimensional box average over a line of ARGB pixels.
// Pixels enter on the s_axis stream in line order, one request at a time.
// Averaged pixels leave on the m_axis stream, lagging the input by radius
// pixels; m_axis_tlast marks the final pixel of each line.
// A pixel that yields no result only passes the check state. Each result
// drops the pixel leaving the window, if any, then runs the 14-step serial
// divider that all four channels share. The last pixel of a line flushes up
// to radius + 1 results before the next pixel is taken. Radius and line
// length are written through cfg_we, cfg_index and cfg_data while the stream
// is idle, a rule for the user that the core does not enforce, and take
// effect with the next pixel. Reset clears the sums, the line position and
// the output register and loads radius 1 and line length 640; the window
// store needs no clearing. A stalled receiver holds the result in the output
// register and blocks further progress once the next result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_blur_line_pass_core
    import bblp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // in_alpha [7:0], in_red [15:8], in_green [23:16], in_blue [31:24]
    input  wire logic [PIX_W-1:0]     s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_alpha [7:0], out_red [15:8], out_green [23:16], out_blue [31:24]
    output logic [PIX_W-1:0]          m_axis_tdata,
    output logic                      m_axis_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bblp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bblp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: bench/blur_line_checker.sv
// ----------------------------------------------------------------------------
// Box blur line pass checker
// Watches the configuration port and both pixel streams of the core. Every
// pixel request that is accepted is run through a local copy of the line
// state to predict the averaged pixels it releases. Each result request is
// then compared per channel and on its end-of-line flag with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blur_line_checker
    import bblp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    // in_alpha [7:0], in_red [15:8], in_green [23:16], in_blue [31:24]
    input  wire logic [PIX_W-1:0]     s_axis_tdata,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_alpha [7:0], out_red [15:8], out_green [23:16], out_blue [31:24]
    input  wire logic [PIX_W-1:0]     m_axis_tdata,
    input  wire logic                 m_axis_tlast,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        chan_vec_t chan;
        logic      eol;
    } blur_pixel_t;

    string chan_label [NUM_CH] = '{"alpha", "red", "green", "blue"};

    logic [RAD_W-1:0] radius_q;
    logic [LEN_W-1:0] line_len_q;
    chan_vec_t        window_ring [STORE_DEPTH];
    sum_vec_t         chan_sum;
    logic [CNT_W-1:0] win_cnt;
    logic [LEN_W-1:0] line_pos;
    blur_pixel_t      blurred_q [$];

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int unsigned r;
        int unsigned len;
        int unsigned p;
        int unsigned x;
        int unsigned limit;
        int unsigned n;
        bit          at_line_end;
        chan_vec_t   px;
        chan_vec_t   old_px;
        chan_vec_t   got;
        logic [SUM_W-1:0] quot;
        blur_pixel_t res;
        blur_pixel_t want;

        if (!rst_n)
        begin
            radius_q   = RADIUS_RESET;
            line_len_q = LINE_LENGTH_RESET;
            chan_sum   = '0;
            win_cnt    = '0;
            line_pos   = '0;
            blurred_q.delete();
            fail_count = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS:      radius_q   = cfg_data[RAD_W-1:0];
                    REG_LINE_LENGTH: line_len_q = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                px  = s_axis_tdata;
                r   = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
                len = (line_len_q == 0) ? 1 : line_len_q;
                p   = line_pos;
                at_line_end = (p + 1 >= len);

                for (int ch = 0; ch < NUM_CH; ch++)
                    chan_sum[ch] = chan_sum[ch] + SUM_W'(px[ch]);
                win_cnt = win_cnt + 1'b1;

                // The last pixel of a line flushes every output still owed.
                x     = (p >= r) ? p - r : 0;
                limit = at_line_end ? STORE_DEPTH : ((p >= r) ? 1 : 0);
                n     = 0;
                while (x < len && n < limit)
                begin
                    if (x >= r + 1)
                    begin
                        old_px = window_ring[(x - r - 1) % STORE_DEPTH];
                        for (int ch = 0; ch < NUM_CH; ch++)
                            chan_sum[ch] = chan_sum[ch] - SUM_W'(old_px[ch]);
                        win_cnt = win_cnt - 1'b1;
                    end
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        quot = (win_cnt == 0) ? '0 : chan_sum[ch] / SUM_W'(win_cnt);
                        res.chan[ch] = quot[CH_W-1:0];
                    end
                    res.eol = (x + 1 == len);
                    blurred_q.push_back(res);
                    n++;
                    x++;
                end

                window_ring[p % STORE_DEPTH] = px;

                if (at_line_end)
                begin
                    chan_sum = '0;
                    win_cnt  = '0;
                    line_pos = '0;
                end
                else
                    line_pos = line_pos + 1'b1;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result request, data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        if (got[ch] !== want.chan[ch])
                        begin
                            $display("%0t: %s mismatch, expected %0d, actual %0d",
                                     $time, chan_label[ch], want.chan[ch], got[ch]);
                            fail_count++;
                        end
                    end
                    if (m_axis_tlast !== want.eol)
                    begin
                        $display("%0t: end-of-line mismatch, expected %b, actual %b",
                                 $time, want.eol, m_axis_tlast);
                        fail_count++;
                    end
                end
            end

            pending <= blurred_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Box blur line pass testbench
// Drives the core with pixel lines under a series of radius and line length
// settings: a short directed run over the register extremes, a radius that
// covers the whole line, saturated sums and a line shortened in mid-line,
// followed by random lines with random stalls on both streams. Checking is
// done by the separate line checker; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bblp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PIXELS  = 135;
    localparam int IDLE_PCT       = 7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RADIUS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_data;
    logic                 m_last;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    int  pixels_sent = 0;
    bit  gaps_on = 1'b1;
    logic pixel_taken = 1'b0;

    always #1 clk = ~clk;

    box_blur_line_pass_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    blur_line_checker i_blur_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        pixel_taken <= s_valid && s_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        m_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] px;
        px = $urandom();
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            case ($urandom_range(7))
                0: px[ch*CH_W +: CH_W] = '0;
                1: px[ch*CH_W +: CH_W] = '1;
                default: ;
            endcase
        end
        return px;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_valid = 1'b0;
            @(negedge clk);
        end
        s_valid = 1'b1;
        s_data  = px;
        do
            @(negedge clk);
        while (!pixel_taken);
        pixels_sent++;
    endtask

    task automatic send_line(input int unsigned count);
        repeat (count)
            send_pixel(rand_pixel());
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_W'($urandom());
    endtask

    task automatic configure(input int unsigned r, input int unsigned len);
        drain_results();
        write_reg(REG_RADIUS, CFG_W'(($urandom_range(2047) << RAD_W) | r));
        write_reg(REG_LINE_LENGTH, CFG_W'(len));
    endtask

    initial
    begin
        int unsigned r;
        int unsigned len;
        int unsigned lines;
        int unsigned head;
        int unsigned shrunk;
        bit paused;

        paused = 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-pixel lines with no averaging, then a zero length and a
        // radius beyond the saturation point.
        configure(0, 1);
        send_pixel('0);
        send_pixel('1);
        configure(31, 0);
        send_pixel('1);
        send_pixel(rand_pixel());

        // Radius covering the whole line.
        configure(16, 5);
        send_pixel('1);
        send_pixel('0);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_FF00);
        send_pixel(rand_pixel());

        configure(2, 6);
        send_pixel('1);
        send_pixel('1);
        send_pixel('1);
        send_line(3);

        // Longest line, cut short while the line is still open.
        configure(3, 65535);
        send_line(8);
        drain_results();
        write_reg(REG_LINE_LENGTH, CFG_W'(7));
        send_pixel(rand_pixel());

        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(9))
                0: r = 0;
                1: r = $urandom_range(17, 31);
                2: r = MAX_RADIUS;
                default: r = $urandom_range(1, 15);
            endcase
            case ($urandom_range(19))
                0: len = 0;
                1: len = 1;
                2, 3, 4: len = $urandom_range(25, 60);
                default: len = $urandom_range(2, 24);
            endcase
            configure(r, len);
            gaps_on = !(pixels_sent >= 40 && pixels_sent < 100);
            if (len == 0)
                len = 1;
            lines = $urandom_range(1, 3);
            if (pixels_sent + lines * len > RANDOM_PIXELS)
                lines = 1;
            repeat (lines)
            begin
                if ($urandom_range(7) == 0 && len > 2)
                begin
                    head = $urandom_range(1, len - 1);
                    send_line(head);
                    drain_results();
                    shrunk = $urandom_range(1, len);
                    write_reg(REG_LINE_LENGTH, CFG_W'(shrunk));
                    len = shrunk;
                    send_line((head + 1 >= shrunk) ? 1 : shrunk - head);
                end
                else
                begin
                    head = $urandom_range(0, len);
                    send_line(head);
                    if (!paused && pixels_sent >= 120)
                    begin
                        s_valid = 1'b0;
                        while (pending != 0)
                            @(negedge clk);
                        paused = 1'b1;
                    end
                    send_line(len - head);
                end
            end
        end

        s_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
